[src/tcrd_pkg.sv]
// ----------------------------------------------------------------------------
// tcrd_pkg
// Shared types and constants for the touch contact/release debounce block.
// ----------------------------------------------------------------------------
package tcrd_pkg;

  // field widths
  localparam int XY_W      = 12;
  localparam int HELD_W    = 39;
  localparam int WIN_W     = 20;
  localparam int STAMP_W   = 48;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 72;

  // register reset values
  localparam logic [WIN_W-1:0] WINDOW_RST = 20'd150000;
  localparam logic [XY_W-1:0]  WIDTH_RST  = 12'd320;
  localparam logic [XY_W-1:0]  HEIGHT_RST = 12'd480;

  localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

  // us -> ms: drop 3 bits (divide by 8), then long division by 125 in
  // 16-bit digits. Digit quotient via exact reciprocal: v < 2^23,
  // floor(v * DIV_M / 2^DIV_S) == floor(v / 125).
  localparam int CHUNK_W = 16;
  localparam int REM_W   = 7;
  localparam int DIG_W   = CHUNK_W + REM_W;
  localparam int DIV_S   = 30;
  localparam int PROD_W  = 2 * DIG_W + 1;
  localparam logic [DIG_W:0] DIV_M = 24'd8589935;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED,
    REG_RELEASE_WINDOW,
    REG_PANEL_WIDTH,
    REG_PANEL_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    OP_POLL,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic            valid_res;
    logic            down;
    logic            pressed;
    logic            released;
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
  } res_t;

endpackage

[src/touch_contact_release_debounce.sv]
// ----------------------------------------------------------------------------
// touch_contact_release_debounce
// Touch contact tracker with release debounce, press/release edges and held
// time in milliseconds.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless a poll item waits on a full result
// pipeline. A poll result passes through one input register, the update
// register for the contact/debounce update and coordinate scaling, then one
// pipeline stage per 16-bit digit of the microsecond-to-millisecond division
// (NCH = ceil((TIME_BITS - 3) / 16) digit stages). A clear item updates
// state in the cycle after acceptance and gives no result. Back-pressure
// on the output stalls the pipeline stage by stage; empty stages still accept.
// Configuration writes are always taken; cfg_ready is tied high.

module touch_contact_release_debounce #(
  parameter int TIME_BITS = 48
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // config write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tcrd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tcrd_pkg::CFG_DAT_W-1:0]          cfg_data,
  // input stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // read_ok[0], status_byte[8:1], x_high[16:9], x_low[24:17],
  // y_high[32:25], y_low[40:33], now_us[88:41], zero pad
  input  logic [tcrd_pkg::IN_TDATA_W-1:0]         s_tdata,
  // op[0]
  input  logic                                    s_tuser,
  // result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // valid_res[0], down[1], pressed[2], released[3], held_ms[42:4],
  // x[54:43], y[66:55], zero pad
  output logic [tcrd_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  localparam int NCH = (TIME_BITS - 3 + tcrd_pkg::CHUNK_W - 1) / tcrd_pkg::CHUNK_W;
  localparam int PW  = NCH * tcrd_pkg::CHUNK_W;
  localparam int QW  = (PW > tcrd_pkg::HELD_W) ? PW : tcrd_pkg::HELD_W;

  // configuration
  logic                          enabled;
  logic [tcrd_pkg::WIN_W-1:0]    release_window_us;
  logic [tcrd_pkg::XY_W-1:0]     panel_width;
  logic [tcrd_pkg::XY_W-1:0]     panel_height;

  // tracking state
  logic                          contact_active;
  logic [TIME_BITS-1:0]          press_start_us;
  logic [TIME_BITS-1:0]          last_contact_us;
  logic [tcrd_pkg::XY_W-1:0]     remembered_x;
  logic [tcrd_pkg::XY_W-1:0]     remembered_y;

  // input register
  logic                          a_v;
  tcrd_pkg::op_t                 a_op;
  logic                          a_read_ok;
  logic [tcrd_pkg::NIB_W-1:0]    a_count;
  logic [tcrd_pkg::XY_W-1:0]     a_x;
  logic [tcrd_pkg::XY_W-1:0]     a_y;
  logic [TIME_BITS-1:0]          a_now;
  logic                          a_adv;

  // result pipeline: stage 0 holds the update result, stage NCH is the output
  logic                          dv        [NCH+1];
  logic                          stage_rdy [NCH+1];
  logic [PW-1:0]                 dw        [NCH+1];
  logic [tcrd_pkg::REM_W-1:0]    dr        [NCH];
  tcrd_pkg::res_t                dres      [NCH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled           <= 1'b0;
      release_window_us <= tcrd_pkg::WINDOW_RST;
      panel_width       <= tcrd_pkg::WIDTH_RST;
      panel_height      <= tcrd_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (tcrd_pkg::cfg_reg_t'(cfg_index))
        tcrd_pkg::REG_ENABLED:        enabled           <= cfg_data[0];
        tcrd_pkg::REG_RELEASE_WINDOW: release_window_us <= cfg_data;
        tcrd_pkg::REG_PANEL_WIDTH:    panel_width       <= cfg_data[tcrd_pkg::XY_W-1:0];
        tcrd_pkg::REG_PANEL_HEIGHT:   panel_height      <= cfg_data[tcrd_pkg::XY_W-1:0];
      endcase
    end
  end

  // ---- handshake chain ----
  always_comb begin
    stage_rdy[NCH] = !dv[NCH] || m_tready;
    for (int k = NCH - 1; k >= 0; k--) begin
      stage_rdy[k] = !dv[k] || stage_rdy[k+1];
    end
  end

  // clear items retire without waiting for the result pipeline
  assign a_adv    = a_v && (a_op == tcrd_pkg::OP_CLEAR || stage_rdy[0]);
  assign s_tready = !a_v || a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (s_tready) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_op      <= tcrd_pkg::op_t'(s_tuser);
      a_read_ok <= s_tdata[0];
      a_count   <= s_tdata[4:1];
      a_x       <= {s_tdata[12:9], s_tdata[24:17]};
      a_y       <= {s_tdata[28:25], s_tdata[40:33]};
      a_now     <= TIME_BITS'(s_tdata[88:41]);
    end
  end

  // ---- contact update ----
  logic                          sampled;
  logic                          out_range;
  logic [2*tcrd_pkg::XY_W-1:0]   x_prod;
  logic [2*tcrd_pkg::XY_W-1:0]   y_prod;
  logic [tcrd_pkg::XY_W-1:0]     x_eff;
  logic [tcrd_pkg::XY_W-1:0]     y_eff;
  logic [TIME_BITS-1:0]          last_eff;
  logic [TIME_BITS-1:0]          since_last;
  logic [TIME_BITS-1:0]          since_press;
  logic [TIME_BITS-1:0]          press_to_last;
  logic                          down;
  logic [TIME_BITS-1:0]          held_us;
  tcrd_pkg::res_t                res;

  always_comb begin
    sampled   = a_read_ok && (a_count != '0);
    out_range = (a_x >= panel_width) || (a_y >= panel_height);
    x_prod    = {{tcrd_pkg::XY_W{1'b0}}, a_x} * {{tcrd_pkg::XY_W{1'b0}}, panel_width};
    y_prod    = {{tcrd_pkg::XY_W{1'b0}}, a_y} * {{tcrd_pkg::XY_W{1'b0}}, panel_height};
    // scale by size/4096
    x_eff     = out_range ? x_prod[2*tcrd_pkg::XY_W-1:tcrd_pkg::XY_W] : a_x;
    y_eff     = out_range ? y_prod[2*tcrd_pkg::XY_W-1:tcrd_pkg::XY_W] : a_y;

    last_eff      = sampled ? a_now : last_contact_us;
    // backwards time counts as zero elapsed
    since_last    = (a_now >= last_eff) ? a_now - last_eff : '0;
    since_press   = (a_now >= press_start_us) ? a_now - press_start_us : '0;
    press_to_last = (last_contact_us >= press_start_us) ?
                    last_contact_us - press_start_us : '0;

    down = sampled ||
           (contact_active && since_last < TIME_BITS'(release_window_us));

    // a fresh press has zero held time
    if (down) begin
      held_us = contact_active ? since_press : '0;
    end else if (contact_active) begin
      held_us = press_to_last;
    end else begin
      held_us = '0;
    end

    res           = '0;
    res.valid_res = 1'b1;
    res.down      = down;
    res.pressed   = down && !contact_active;
    res.released  = !down && contact_active;
    res.x         = sampled ? x_eff : remembered_x;
    res.y         = sampled ? y_eff : remembered_y;
    if (!enabled) begin
      res     = '0;
      held_us = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_active  <= 1'b0;
      press_start_us  <= '0;
      last_contact_us <= '0;
      remembered_x    <= '0;
      remembered_y    <= '0;
    end else if (a_adv) begin
      if (a_op == tcrd_pkg::OP_CLEAR) begin
        contact_active  <= 1'b0;
        press_start_us  <= '0;
        last_contact_us <= '0;
      end else if (enabled) begin
        contact_active  <= down;
        last_contact_us <= last_eff;
        if (down && !contact_active) begin
          press_start_us <= a_now;
        end
        if (sampled) begin
          remembered_x <= x_eff;
          remembered_y <= y_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (stage_rdy[0]) begin
      dv[0] <= a_adv && (a_op == tcrd_pkg::OP_POLL);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[0] && a_adv && a_op == tcrd_pkg::OP_POLL) begin
      dw[0]   <= PW'(held_us >> 3);
      dr[0]   <= '0;
      dres[0] <= res;
    end
  end

  // ---- divide by 125, one digit per stage, most significant first ----
  for (genvar k = 0; k < NCH; k++) begin : g_div
    localparam int HI = PW - 1 - k * tcrd_pkg::CHUNK_W;

    logic [tcrd_pkg::DIG_W-1:0]   v;
    logic [tcrd_pkg::PROD_W-1:0]  prod;
    logic [tcrd_pkg::CHUNK_W-1:0] q;
    logic [tcrd_pkg::DIG_W-1:0]   q_x;
    logic [tcrd_pkg::DIG_W-1:0]   back;
    logic [tcrd_pkg::DIG_W-1:0]   diff;
    logic [PW-1:0]                w_next;

    always_comb begin
      v      = {dr[k], dw[k][HI -: tcrd_pkg::CHUNK_W]};
      prod   = tcrd_pkg::PROD_W'(v) * tcrd_pkg::PROD_W'(tcrd_pkg::DIV_M);
      q      = prod[tcrd_pkg::DIV_S +: tcrd_pkg::CHUNK_W];
      q_x    = tcrd_pkg::DIG_W'(q);
      back   = (q_x << 7) - (q_x << 1) - q_x;   // q * 125
      diff   = v - back;
      w_next = dw[k];
      w_next[HI -: tcrd_pkg::CHUNK_W] = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (stage_rdy[k+1]) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_rdy[k+1] && dv[k]) begin
        dw[k+1]   <= w_next;
        dres[k+1] <= dres[k];
      end
    end

    if (k < NCH - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (stage_rdy[k+1] && dv[k]) begin
          dr[k+1] <= diff[tcrd_pkg::REM_W-1:0];
        end
      end
    end
  end

  // ---- output ----
  logic [QW-1:0]                 held_q;
  logic [tcrd_pkg::HELD_W-1:0]   held_ms;

  always_comb begin
    held_q  = QW'(dw[NCH]);
    held_ms = (held_q > QW'(tcrd_pkg::HELD_MAX)) ? tcrd_pkg::HELD_MAX
                                                 : held_q[tcrd_pkg::HELD_W-1:0];
  end

  assign m_tvalid = dv[NCH];
  assign m_tdata  = {5'b0, dres[NCH].y, dres[NCH].x, held_ms, dres[NCH].released,
                     dres[NCH].pressed, dres[NCH].down, dres[NCH].valid_res};

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch contact/release debounce block. Poll and
// clear items go in on the input stream. A local model of the contact tracker
// predicts every poll result, and each result leaving the block is compared
// field by field, in order. The run covers directed edge cases, then random
// touch gestures mixed with noise under four handshake pressure phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrd_pkg::*;

  localparam int LATENCY     = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int US_PER_MS   = 1000;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    op_t                op;
    logic               read_ok;
    logic [BYTE_W-1:0]  status;
    logic [BYTE_W-1:0]  x_high;
    logic [BYTE_W-1:0]  x_low;
    logic [BYTE_W-1:0]  y_high;
    logic [BYTE_W-1:0]  y_low;
    logic [STAMP_W-1:0] now_us;
  } poll_item_t;

  typedef struct packed {
    logic              valid_res;
    logic              down;
    logic              pressed;
    logic              released;
    logic [HELD_W-1:0] held_ms;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
  } touch_res_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  touch_contact_release_debounce #(.TIME_BITS(STAMP_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // tracker copy: registers and contact state
  logic               reg_enabled = 1'b0;
  logic [WIN_W-1:0]   reg_window  = WINDOW_RST;
  logic [XY_W-1:0]    reg_width   = WIDTH_RST;
  logic [XY_W-1:0]    reg_height  = HEIGHT_RST;
  logic               trk_active   = 1'b0;
  logic [STAMP_W-1:0] trk_press_us = '0;
  logic [STAMP_W-1:0] trk_last_us  = '0;
  logic [XY_W-1:0]    trk_x = '0;
  logic [XY_W-1:0]    trk_y = '0;

  touch_res_t pending_results[$];
  touch_res_t seen_res;
  touch_res_t want_res;

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int errors          = 0;
  int polls_sent      = 0;
  int clears_sent     = 0;
  int results_checked = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("cycle limit reached with %0d results outstanding", pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [STAMP_W-1:0] span_us(input logic [STAMP_W-1:0] later,
                                                  input logic [STAMP_W-1:0] earlier);
    return (later >= earlier) ? later - earlier : '0;
  endfunction

  function automatic logic [HELD_W-1:0] us_to_ms(input logic [STAMP_W-1:0] us);
    logic [STAMP_W-1:0] ms;
    ms = us / US_PER_MS;
    if (ms > HELD_MAX) return HELD_MAX;
    return ms[HELD_W-1:0];
  endfunction

  // Advances the tracker copy by one item; returns 1 when a result is due.
  function automatic bit track_contact(input poll_item_t it, output touch_res_t r);
    logic [XY_W-1:0]   xv;
    logic [XY_W-1:0]   yv;
    logic [2*XY_W-1:0] px;
    logic [2*XY_W-1:0] py;
    logic              sampled;
    logic              now_down;
    r = '0;
    if (it.op == OP_CLEAR) begin
      trk_active   = 1'b0;
      trk_press_us = '0;
      trk_last_us  = '0;
      return 0;
    end
    if (!reg_enabled) return 1;
    xv = {it.x_high[NIB_W-1:0], it.x_low};
    yv = {it.y_high[NIB_W-1:0], it.y_low};
    sampled = it.read_ok && (it.status[NIB_W-1:0] != '0);
    if (sampled) begin
      // out of panel: scale both by size/4096
      if (xv >= reg_width || yv >= reg_height) begin
        px = xv * reg_width;
        py = yv * reg_height;
        xv = px[2*XY_W-1:XY_W];
        yv = py[2*XY_W-1:XY_W];
      end
      trk_last_us = it.now_us;
    end
    now_down = sampled || (trk_active && (span_us(it.now_us, trk_last_us) < reg_window));
    r.valid_res = 1'b1;
    r.down      = now_down;
    r.pressed   = now_down && !trk_active;
    r.released  = !now_down && trk_active;
    if (now_down) begin
      if (!trk_active) trk_press_us = it.now_us;
      r.held_ms = us_to_ms(span_us(it.now_us, trk_press_us));
      if (sampled) begin
        trk_x = xv;
        trk_y = yv;
      end
    end else if (trk_active) begin
      r.held_ms = us_to_ms(span_us(trk_last_us, trk_press_us));
    end
    r.x = trk_x;
    r.y = trk_y;
    trk_active = now_down;
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
               results_checked, what, got, want);
    errors++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res.valid_res = m_tdata[0];
      seen_res.down      = m_tdata[1];
      seen_res.pressed   = m_tdata[2];
      seen_res.released  = m_tdata[3];
      seen_res.held_ms   = m_tdata[42:4];
      seen_res.x         = m_tdata[54:43];
      seen_res.y         = m_tdata[66:55];
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", m_tdata, '0);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res.valid_res !== want_res.valid_res)
          report_mismatch("valid_res", seen_res.valid_res, want_res.valid_res);
        if (seen_res.down !== want_res.down)
          report_mismatch("down", seen_res.down, want_res.down);
        if (seen_res.pressed !== want_res.pressed)
          report_mismatch("pressed", seen_res.pressed, want_res.pressed);
        if (seen_res.released !== want_res.released)
          report_mismatch("released", seen_res.released, want_res.released);
        if (seen_res.held_ms !== want_res.held_ms)
          report_mismatch("held_ms", seen_res.held_ms, want_res.held_ms);
        if (seen_res.x !== want_res.x)
          report_mismatch("x", seen_res.x, want_res.x);
        if (seen_res.y !== want_res.y)
          report_mismatch("y", seen_res.y, want_res.y);
      end
      results_checked++;
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input poll_item_t it);
    touch_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-89){1'b0}}, it.now_us, it.y_low, it.y_high,
                 it.x_low, it.x_high, it.status, it.read_ok};
    s_tuser  <= it.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (track_contact(it, r)) pending_results.push_back(r);
    if (it.op == OP_CLEAR) clears_sent++;
    else polls_sent++;
  endtask

  // upper nibbles of the high bytes are junk the block must ignore
  task automatic send_poll(input logic ok, input logic [BYTE_W-1:0] status,
                           input logic [XY_W-1:0] px, input logic [XY_W-1:0] py,
                           input logic [STAMP_W-1:0] t);
    poll_item_t it;
    it.op      = OP_POLL;
    it.read_ok = ok;
    it.status  = status;
    it.x_high  = $urandom_range(255);
    it.x_high[NIB_W-1:0] = px[XY_W-1:BYTE_W];
    it.x_low   = px[BYTE_W-1:0];
    it.y_high  = $urandom_range(255);
    it.y_high[NIB_W-1:0] = py[XY_W-1:BYTE_W];
    it.y_low   = py[BYTE_W-1:0];
    it.now_us  = t;
    send_item(it);
  endtask

  task automatic send_clear(input logic [STAMP_W-1:0] t);
    poll_item_t it;
    it = {$urandom, $urandom, $urandom};
    it.op     = OP_CLEAR;
    it.now_us = t;
    send_item(it);
  endtask

  // sender holds off until every pending result is out, then lets a clear settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLED:        reg_enabled = val[0];
      REG_RELEASE_WINDOW: reg_window  = val[WIN_W-1:0];
      REG_PANEL_WIDTH:    reg_width   = val[XY_W-1:0];
      REG_PANEL_HEIGHT:   reg_height  = val[XY_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [XY_W-1:0] pick_size();
    case ($urandom_range(3))
      0:       return 1;
      1:       return 4095;
      2:       return $urandom_range(200, 800);
      default: return $urandom_range(1, 4095);
    endcase
  endfunction

  function automatic logic [XY_W-1:0] pick_coord(input logic [XY_W-1:0] limit);
    case ($urandom_range(3))
      0:       return $urandom_range(0, limit - 1);
      1:       return (limit == 0) ? '0 : limit - $urandom_range(0, 1);
      default: return $urandom_range(4095);
    endcase
  endfunction

  // block is disabled out of reset: polls answer zeroed, clears still apply
  task automatic test_disabled_polls();
    send_poll(1'b1, 8'h01, 12'd100, 12'd100, 48'd10);
    send_clear(48'd20);
    send_poll(1'b1, 8'hFF, 12'hFFF, 12'hFFF, 48'd30);
    drain_results();
  endtask

  // press, scaling, debounce hold, backwards time, release, clear, long hold
  task automatic test_contact_edges();
    write_reg(REG_ENABLED, 1);
    send_poll(1'b0, 8'h01, 12'd50, 12'd50, 48'd100);
    send_poll(1'b1, 8'hF0, 12'd50, 12'd50, 48'd200);
    send_poll(1'b1, 8'h01, 12'd100, 12'd200, 48'd1000);
    send_poll(1'b1, 8'hFF, 12'hFFF, 12'hFFF, 48'd2000);
    send_poll(1'b1, 8'h0F, 12'd319, 12'd479, 48'd3000);
    send_poll(1'b1, 8'h81, 12'd320, 12'd0, 48'd4000);
    send_poll(1'b0, 8'h00, 12'd0, 12'd0, 48'd100000);
    send_poll(1'b1, 8'h00, 12'd0, 12'd0, 48'd500);
    send_poll(1'b0, 8'hFF, 12'd0, 12'd0, 48'd153999);
    send_poll(1'b0, 8'hFF, 12'd0, 12'd0, 48'd154000);
    send_poll(1'b1, 8'h70, 12'd0, 12'd0, 48'd200000);
    send_clear(48'd200100);
    send_poll(1'b0, 8'h00, 12'd0, 12'd0, 48'd200);
    send_poll(1'b1, 8'h01, 12'd7, 12'd9, 48'd0);
    send_poll(1'b1, 8'h02, 12'd8, 12'd10, 48'hFFFF_FFFF_FFFF);
    send_clear(48'hFFFF_FFFF_FFFF);
    drain_results();
  endtask

  // smallest and largest panel sizes, zero size, zero and wide window
  task automatic test_panel_extremes();
    write_reg(REG_PANEL_WIDTH, 1);
    write_reg(REG_PANEL_HEIGHT, 4095);
    write_reg(REG_RELEASE_WINDOW, 0);
    send_poll(1'b1, 8'h01, 12'd0, 12'd4095, 48'd1000);
    send_poll(1'b0, 8'h01, 12'd0, 12'd0, 48'd1000);
    send_poll(1'b1, 8'h05, 12'd4095, 12'd0, 48'd2000);
    drain_results();
    // a zero size puts every value out of range
    write_reg(REG_PANEL_WIDTH, 0);
    write_reg(REG_PANEL_HEIGHT, 0);
    send_poll(1'b1, 8'h01, 12'd4095, 12'd4095, 48'd3000);
    send_poll(1'b1, 8'h01, 12'd0, 12'd0, 48'd4000);
    drain_results();
    write_reg(REG_RELEASE_WINDOW, 1000000);
    write_reg(REG_PANEL_WIDTH, 4095);
    write_reg(REG_PANEL_HEIGHT, 4095);
    send_clear(48'd5);
    send_poll(1'b1, 8'h01, 12'd4094, 12'd4095, 48'd10);
    send_poll(1'b0, 8'h01, 12'd0, 12'd0, 48'd1000009);
    send_poll(1'b0, 8'h01, 12'd0, 12'd0, 48'd1000010);
    drain_results();
  endtask

  // Mostly whole gestures (contact reads, missed reads, gap) with random
  // content, the rest noise: random fields, clears, time jumps both ways.
  task automatic test_random_phase(input int idle, input int stall, input int n_items);
    int                 sent;
    int                 nc;
    int                 nm;
    int                 seg;
    logic               ok;
    logic [BYTE_W-1:0]  st;
    logic [XY_W-1:0]    gx;
    logic [XY_W-1:0]    gy;
    logic [STAMP_W-1:0] stamp;
    logic [CFG_DAT_W-1:0] win;
    send_idle_pct = idle;
    stall_pct     = stall;
    stamp = $urandom_range(1000);
    for (seg = 0; seg < 2; seg++) begin
      drain_results();
      case ($urandom_range(3))
        0:       win = 0;
        1:       win = 1000000;
        2:       win = WINDOW_RST;
        default: win = $urandom_range(1000000);
      endcase
      write_reg(REG_RELEASE_WINDOW, win);
      write_reg(REG_PANEL_WIDTH, pick_size());
      write_reg(REG_PANEL_HEIGHT, pick_size());
      write_reg(REG_ENABLED, ($urandom_range(7) != 0));
      sent = 0;
      while (sent < n_items / 2) begin
        if ($urandom_range(9) < 8) begin
          gx = pick_coord(reg_width);
          gy = pick_coord(reg_height);
          stamp = stamp + $urandom_range(0, 2 * reg_window + 5000);
          for (nc = $urandom_range(1, 8); nc > 0; nc--) begin
            st = $urandom_range(255);
            st[NIB_W-1:0] = $urandom_range(1, 15);
            gx = gx + $urandom_range(0, 6) - 3;
            gy = gy + $urandom_range(0, 6) - 3;
            stamp = stamp + $urandom_range(2000, 30000);
            send_poll(1'b1, st, gx, gy, stamp);
            sent++;
          end
          for (nm = $urandom_range(0, 4); nm > 0; nm--) begin
            st = $urandom_range(255);
            ok = $urandom_range(1);
            if (ok) st[NIB_W-1:0] = '0;
            stamp = stamp + $urandom_range(0, reg_window + reg_window / 2 + 1000);
            send_poll(ok, st, $urandom_range(4095), $urandom_range(4095), stamp);
            sent++;
          end
        end else begin
          case ($urandom_range(9))
            0:       stamp = {$urandom, $urandom};
            1:       stamp = stamp - $urandom_range(0, 300000);
            default: stamp = stamp + $urandom_range(0, 200000);
          endcase
          if ($urandom_range(3) == 0)
            send_clear(stamp);
          else
            send_poll($urandom_range(1), $urandom_range(255), $urandom_range(4095),
                      $urandom_range(4095), stamp);
          sent++;
        end
        if ($urandom_range(39) == 0) drain_results();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_polls();
    test_contact_edges();
    test_panel_extremes();
    test_random_phase(0, 0, 210);
    test_random_phase(85, 0, 210);
    test_random_phase(0, 85, 210);
    test_random_phase(21, 21, 210);
    drain_results();
    $display("sent %0d polls and %0d clears, checked %0d results", polls_sent, clears_sent,
             results_checked);
    $display("covered disabled polls, edges, panel extremes and random gestures under stalls");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
